@@ src/fcal_pkg.sv @@
// Shared types and constants for the fixed-capacity array list core.
// Used by fcal_ram, fcal_ctrl and fixed_capacity_array_list_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package fcal_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = 7;   // position, count and limit width
    localparam int FIDX_W       = 6;
    localparam int LIMIT_RESET  = 64;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 48;

    typedef enum logic [2:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_UPDATE = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_FIND   = 3'd4,
        MODE_CLEAR  = 3'd5,
        MODE_READ   = 3'd6,
        MODE_NOP    = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_DRAIN,
        S_FIN,
        S_FIND,
        S_RDW,
        S_DONE
    } state_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [DATA_W-1:0]  value;
        logic [IDX_W-1:0]          position;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic [FIDX_W-1:0]         found_index;
        logic signed [DATA_W-1:0]  read_value;
        logic [IDX_W-1:0]          entry_count;
    } res_t;

endpackage
`default_nettype wire

@@ src/fcal_ram.sv @@
// Entry store: single write port, one read port with registered read data.
// Depends on fcal_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none
module fcal_ram #(
    parameter int DEPTH  = fcal_pkg::CAPACITY_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [ADDR_W-1:0]           waddr,
    input  wire logic [fcal_pkg::DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0]           raddr,
    output logic      [fcal_pkg::DATA_W-1:0] rdata
);

    logic [fcal_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ src/fcal_ctrl.sv @@
// Sequencer for the list operations: one index step unit walks the entry store
// for shifts and searches. Depends on fcal_pkg; drives an external fcal_ram.
`timescale 1ns / 1ps
`default_nettype none
module fcal_ctrl #(
    parameter int CAPACITY = fcal_pkg::CAPACITY_DEF,
    parameter int ADDR_W   = $clog2(CAPACITY)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire fcal_pkg::req_t              req,
    input  wire logic [fcal_pkg::IDX_W-1:0]  eff_limit,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output fcal_pkg::res_t                   res,
    output logic                             ram_we,
    output logic [ADDR_W-1:0]                ram_waddr,
    output logic [fcal_pkg::DATA_W-1:0]      ram_wdata,
    output logic [ADDR_W-1:0]                ram_raddr,
    input  wire logic [fcal_pkg::DATA_W-1:0] ram_rdata
);

    localparam int IW = fcal_pkg::IDX_W;

    fcal_pkg::state_t  state_reg, state_next;
    fcal_pkg::mode_t   mode_reg, mode_next;
    logic [fcal_pkg::DATA_W-1:0] value_reg, value_next;
    logic [IW-1:0]     pos_reg, pos_next;
    logic [IW-1:0]     count_reg, count_next;
    logic [IW-1:0]     rd_idx_reg, rd_idx_next;
    logic [IW-1:0]     wr_idx_reg, wr_idx_next;
    logic              pend_reg, pend_next;
    fcal_pkg::status_t status_reg, status_next;
    logic [fcal_pkg::FIDX_W-1:0] fidx_reg, fidx_next;
    logic [fcal_pkg::DATA_W-1:0] rval_reg, rval_next;

    // shared index step unit and compare terms
    logic [IW-1:0] idx_inc, idx_dec, shift_end;
    logic          is_ins, full, pos_le_cnt, pos_lt_cnt, pos_tail;
    logic          shift_last, hit, find_more;

    always_comb
    begin
        idx_inc    = rd_idx_reg + IW'(1);
        idx_dec    = rd_idx_reg - IW'(1);
        is_ins     = (mode_reg == fcal_pkg::MODE_INSERT);
        full       = (count_reg >= eff_limit);
        pos_le_cnt = (pos_reg <= count_reg);
        pos_lt_cnt = (pos_reg < count_reg);
        pos_tail   = ((pos_reg + IW'(1)) == count_reg);
        shift_end  = is_ins ? pos_reg : (count_reg - IW'(1));
        shift_last = (rd_idx_reg == shift_end);
        hit        = pend_reg && (ram_rdata == value_reg);
        find_more  = (rd_idx_reg < count_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fcal_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = fcal_pkg::S_EXEC;
                end
            end
            fcal_pkg::S_EXEC:
            begin
                state_next = fcal_pkg::S_DONE;
                unique case (mode_reg)
                    fcal_pkg::MODE_INSERT:
                    begin
                        if (!full && pos_lt_cnt)
                        begin
                            state_next = fcal_pkg::S_SHIFT;
                        end
                    end
                    fcal_pkg::MODE_REMOVE:
                    begin
                        if (pos_lt_cnt)
                        begin
                            state_next = pos_tail ? fcal_pkg::S_FIN : fcal_pkg::S_SHIFT;
                        end
                    end
                    fcal_pkg::MODE_FIND:
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = fcal_pkg::S_FIND;
                        end
                    end
                    fcal_pkg::MODE_READ:
                    begin
                        if (pos_lt_cnt)
                        begin
                            state_next = fcal_pkg::S_RDW;
                        end
                    end
                    default:
                    begin
                        state_next = fcal_pkg::S_DONE;
                    end
                endcase
            end
            fcal_pkg::S_SHIFT:
            begin
                if (shift_last)
                begin
                    state_next = fcal_pkg::S_DRAIN;
                end
            end
            fcal_pkg::S_DRAIN: state_next = fcal_pkg::S_FIN;
            fcal_pkg::S_FIN:   state_next = fcal_pkg::S_DONE;
            fcal_pkg::S_FIND:
            begin
                if (hit || !find_more)
                begin
                    state_next = fcal_pkg::S_DONE;
                end
            end
            fcal_pkg::S_RDW:   state_next = fcal_pkg::S_DONE;
            fcal_pkg::S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = fcal_pkg::S_IDLE;
                end
            end
            default: state_next = fcal_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        mode_next   = mode_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        pend_next   = pend_reg;
        status_next = status_reg;
        fidx_next   = fidx_reg;
        rval_next   = rval_reg;
        ram_we      = 1'b0;
        ram_waddr   = ADDR_W'(wr_idx_reg);
        ram_wdata   = ram_rdata;
        ram_raddr   = ADDR_W'(rd_idx_reg);

        unique case (state_reg)
            fcal_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next   = req.mode;
                    value_next  = req.value;
                    pos_next    = req.position;
                    status_next = fcal_pkg::ST_OK;
                    fidx_next   = '0;
                    rval_next   = '0;
                end
            end
            fcal_pkg::S_EXEC:
            begin
                ram_wdata = value_reg;
                pend_next = 1'b0;
                unique case (mode_reg)
                    fcal_pkg::MODE_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = fcal_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = ADDR_W'(count_reg);
                            count_next = count_reg + IW'(1);
                        end
                    end
                    fcal_pkg::MODE_INSERT:
                    begin
                        priority if (full)
                        begin
                            status_next = fcal_pkg::ST_FULL;
                        end
                        else if (!pos_le_cnt)
                        begin
                            status_next = fcal_pkg::ST_RANGE;
                        end
                        else if (!pos_lt_cnt)
                        begin
                            // insert at the tail: no shift
                            ram_we     = 1'b1;
                            ram_waddr  = ADDR_W'(pos_reg);
                            count_next = count_reg + IW'(1);
                        end
                        else
                        begin
                            rd_idx_next = count_reg - IW'(1);
                        end
                    end
                    fcal_pkg::MODE_UPDATE:
                    begin
                        if (!pos_lt_cnt)
                        begin
                            status_next = fcal_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = ADDR_W'(pos_reg);
                        end
                    end
                    fcal_pkg::MODE_REMOVE:
                    begin
                        if (!pos_lt_cnt)
                        begin
                            status_next = fcal_pkg::ST_RANGE;
                        end
                        else
                        begin
                            rd_idx_next = pos_reg + IW'(1);
                        end
                    end
                    fcal_pkg::MODE_FIND:
                    begin
                        rd_idx_next = '0;
                        if (count_reg == '0)
                        begin
                            status_next = fcal_pkg::ST_NOT_FOUND;
                        end
                    end
                    fcal_pkg::MODE_CLEAR:
                    begin
                        count_next = '0;
                    end
                    fcal_pkg::MODE_READ:
                    begin
                        ram_raddr = ADDR_W'(pos_reg);
                        if (!pos_lt_cnt)
                        begin
                            status_next = fcal_pkg::ST_RANGE;
                        end
                    end
                    fcal_pkg::MODE_NOP:
                    begin
                        status_next = fcal_pkg::ST_OK;
                    end
                endcase
            end
            fcal_pkg::S_SHIFT:
            begin
                // read one slot ahead, write the previous read one slot over
                ram_we      = pend_reg;
                pend_next   = 1'b1;
                wr_idx_next = is_ins ? idx_inc : idx_dec;
                rd_idx_next = is_ins ? idx_dec : idx_inc;
            end
            fcal_pkg::S_DRAIN:
            begin
                ram_we    = pend_reg;
                pend_next = 1'b0;
            end
            fcal_pkg::S_FIN:
            begin
                if (is_ins)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = ADDR_W'(pos_reg);
                    ram_wdata  = value_reg;
                    count_next = count_reg + IW'(1);
                end
                else
                begin
                    count_next = count_reg - IW'(1);
                end
            end
            fcal_pkg::S_FIND:
            begin
                priority if (hit)
                begin
                    status_next = fcal_pkg::ST_OK;
                    fidx_next   = wr_idx_reg[fcal_pkg::FIDX_W-1:0];
                end
                else if (find_more)
                begin
                    pend_next   = 1'b1;
                    wr_idx_next = rd_idx_reg;
                    rd_idx_next = idx_inc;
                end
                else
                begin
                    status_next = fcal_pkg::ST_NOT_FOUND;
                end
            end
            fcal_pkg::S_RDW:
            begin
                rval_next = ram_rdata;
            end
            fcal_pkg::S_DONE:
            begin
                pend_next = 1'b0;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        req_ready           = (state_reg == fcal_pkg::S_IDLE);
        res_valid           = (state_reg == fcal_pkg::S_DONE);
        res.status          = status_reg;
        res.found_index     = fidx_reg;
        res.read_value      = rval_reg;
        res.entry_count     = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcal_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        rd_idx_reg <= rd_idx_next;
        wr_idx_reg <= wr_idx_next;
        status_reg <= status_next;
        fidx_reg   <= fidx_next;
        rval_reg   <= rval_next;
    end

endmodule
`default_nettype wire

@@ src/fixed_capacity_array_list_core.sv @@
// Top level of the fixed-capacity array list: stream ports, limit register,
// output register. Depends on fcal_pkg, fcal_ram and fcal_ctrl.
//
// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  s_tdata: mode, value, position
// m_axis    out        m_tvalid/m_tready  m_tdata: status, found_index, read_value, entry_count
// cfg       in         cfg_valid/cfg_ready cfg_data: capacity_limit
//
// One request at a time. Append, update, clear, no-op, failed checks, find on an
// empty list and insert at the tail go from S_EXEC straight to S_DONE; read passes
// S_RDW and removal of the last entry passes S_FIN; insert and remove that move
// entries walk them in S_SHIFT, then S_DRAIN and S_FIN; find compares in S_FIND. The
// memory's single read and write port sets the one-entry-per-cycle walk.
// Reset clears the count and sets the limit to 64; no clearing pass. A result
// waiting in the output register holds the next result, and so the next request, in S_DONE.
`timescale 1ns / 1ps
`default_nettype none
module fixed_capacity_array_list_core #(
    parameter int CAPACITY = fcal_pkg::CAPACITY_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // [2:0] mode, [34:3] value, [41:35] position, [47:42] zero
    input  wire logic [fcal_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [1:0] status, [7:2] found_index, [39:8] read_value, [46:40] entry_count, [47] zero
    output logic [fcal_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [fcal_pkg::IDX_W-1:0]        cfg_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int IW     = fcal_pkg::IDX_W;

    logic [IW-1:0]   limit_reg;
    logic [IW-1:0]   eff_limit;
    fcal_pkg::req_t  req;
    fcal_pkg::res_t  res;
    logic            res_valid, res_ready;
    logic            ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [fcal_pkg::DATA_W-1:0] ram_wdata, ram_rdata;
    logic            out_valid_reg;
    logic [fcal_pkg::OUT_TDATA_W-1:0] out_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= IW'(fcal_pkg::LIMIT_RESET);
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    // clamp the limit register to the store depth
    assign eff_limit = (32'(limit_reg) < CAPACITY) ? limit_reg : IW'(CAPACITY);

    assign req.mode     = fcal_pkg::mode_t'(s_tdata[2:0]);
    assign req.value    = s_tdata[34:3];
    assign req.position = s_tdata[41:35];

    fcal_ctrl #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .eff_limit (eff_limit),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    fcal_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register: load whenever it is empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= {1'b0, res.entry_count, res.read_value,
                             res.found_index, res.status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[46:40]) <= CAPACITY))
        else $error("entry count above capacity");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while busy");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != fcal_pkg::ST_OK)) |->
            ((m_tdata[7:2] == '0) && (m_tdata[39:8] == '0)))
        else $error("failed request carries index or data");

    a_limit_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        32'(eff_limit) <= CAPACITY)
        else $error("effective limit above capacity");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for fixed_capacity_array_list_core: drives list requests and
// limit writes, checks each result against the in-bench list model or the plan.
// Depends on fcal_pkg and the core RTL.
module tb_top;
    import fcal_pkg::*;

    localparam int LIST_DEPTH = CAPACITY_DEF;
    localparam int MAX_SHOWN  = 10;
    localparam int N_PHASES   = 9;

    typedef struct packed {
        status_t     status;
        logic [5:0]  found;
        logic [31:0] rdval;
        logic [6:0]  count;
    } list_result_t;

    typedef struct {
        bit           is_cfg;
        mode_t        mode;
        logic [31:0]  value;
        logic [6:0]   position;
        bit           typed;
        list_result_t res;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [IDX_W-1:0]       cfg_data;
    logic                   cfg_valid;
    logic                   cfg_ready;

    // list model
    logic [31:0]  list_mem [LIST_DEPTH];
    int unsigned  list_len;
    int unsigned  list_limit;
    list_result_t pending [$];
    plan_row_t    plan_rows [$];

    int  mismatches;
    int  sent_count;
    int  cfg_writes;
    int  peak_len;
    int  rx_seen;
    int  phase_left;
    int  status_seen [4];
    bit  tx_steady;
    bit  rx_steady;
    bit  hold_done;

    fixed_capacity_array_list_core #(
        .CAPACITY (LIST_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic list_result_t predict_list_op(input mode_t m, input logic [31:0] v,
                                                     input logic [6:0] p);
        list_result_t r;
        int unsigned  room;
        int           i;
        r = '{ST_OK, 6'd0, 32'd0, 7'd0};
        room = (list_limit < LIST_DEPTH) ? list_limit : LIST_DEPTH;
        case (m)
            MODE_APPEND:
            begin
                if (list_len >= room)
                    r.status = ST_FULL;
                else
                begin
                    list_mem[list_len] = v;
                    list_len++;
                end
            end
            MODE_INSERT:
            begin
                // full wins over a bad position
                if (list_len >= room)
                    r.status = ST_FULL;
                else if (p > list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = list_len; i > p; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p] = v;
                    list_len++;
                end
            end
            MODE_UPDATE:
            begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else
                    list_mem[p] = v;
            end
            MODE_REMOVE:
            begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = p; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            MODE_FIND:
            begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < list_len && r.status != ST_OK; i++)
                begin
                    if (list_mem[i] == v)
                    begin
                        r.status = ST_OK;
                        r.found  = i[5:0];
                    end
                end
            end
            MODE_CLEAR:
                list_len = 0;
            MODE_READ:
            begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else
                    r.rdval = list_mem[p];
            end
            default:
                ;
        endcase
        r.count = list_len[6:0];
        return r;
    endfunction

    function automatic void plan_op(input mode_t m, input logic [31:0] v, input logic [6:0] p,
                                    input bit typed = 1'b0, input status_t st = ST_OK,
                                    input logic [6:0] cnt = 7'd0);
        plan_row_t row;
        row.is_cfg   = 1'b0;
        row.mode     = m;
        row.value    = v;
        row.position = p;
        row.typed    = typed;
        row.res      = '{st, 6'd0, 32'd0, cnt};
        plan_rows.push_back(row);
    endfunction

    function automatic void plan_limit(input logic [6:0] lim);
        plan_row_t row;
        row.is_cfg   = 1'b1;
        row.mode     = MODE_NOP;
        row.value    = {25'd0, lim};
        row.position = 7'd0;
        row.typed    = 1'b0;
        row.res      = '0;
        plan_rows.push_back(row);
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        // narrow pool so duplicates show up for find
        if (r <= 3)
            return 32'($signed($urandom_range(0, 6)) - 3);
        return $urandom;
    endfunction

    function automatic void pick_request(input bit grow, output mode_t m,
                                         output logic [31:0] v, output logic [6:0] p);
        int r;
        r = $urandom_range(0, 99);
        if (grow)
        begin
            if (r < 35)      m = MODE_APPEND;
            else if (r < 55) m = MODE_INSERT;
            else if (r < 65) m = MODE_UPDATE;
            else if (r < 72) m = MODE_REMOVE;
            else if (r < 84) m = MODE_FIND;
            else if (r < 98) m = MODE_READ;
            else if (r < 99) m = MODE_CLEAR;
            else             m = MODE_NOP;
        end
        else
        begin
            if (r < 10)      m = MODE_APPEND;
            else if (r < 20) m = MODE_INSERT;
            else if (r < 30) m = MODE_UPDATE;
            else if (r < 62) m = MODE_REMOVE;
            else if (r < 77) m = MODE_FIND;
            else if (r < 92) m = MODE_READ;
            else if (r < 96) m = MODE_CLEAR;
            else             m = MODE_NOP;
        end
        v = pick_word();
        if (m == MODE_FIND && list_len > 0 && $urandom_range(0, 9) < 6)
            v = list_mem[$urandom_range(0, list_len - 1)];
        if ($urandom_range(0, 99) < 15)
            p = 7'($urandom_range(0, 127));
        else
            p = 7'($urandom_range(0, list_len));
    endfunction

    function automatic void check_result(input list_result_t got);
        list_result_t want;
        status_seen[got.status]++;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("result %0d arrived with no request pending", rx_seen);
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status || got.found !== want.found ||
            got.rdval !== want.rdval || got.count !== want.count)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display({"result %0d mismatch: expected status %0d index %0d value %0d ",
                          "count %0d, got status %0d index %0d value %0d count %0d"},
                         rx_seen, want.status, want.found, $signed(want.rdval), want.count,
                         got.status, got.found, $signed(got.rdval), got.count);
        end
    endfunction

    task automatic send_request(input mode_t m, input logic [31:0] v, input logic [6:0] p,
                                input bit typed, input list_result_t typed_res);
        int           gap;
        list_result_t r;
        gap = tx_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {6'd0, p, v, m};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        r = predict_list_op(m, v, p);
        pending.push_back(typed ? typed_res : r);
        sent_count++;
        if (r.count > peak_len)
            peak_len = r.count;
    endtask

    task automatic wait_list_idle();
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
    endtask

    task automatic write_limit(input logic [6:0] lim);
        @(posedge clk);
        cfg_data  <= lim;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        list_limit = lim;
        cfg_writes++;
    endtask

    initial
    begin : result_sink
        int           stall;
        list_result_t got;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_seen % 32 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            stall = rx_steady ? 0 : $urandom_range(0, 19);
            // one long hold-off mid-phase so the core backs up and stalls its input
            if (!hold_done && rx_seen >= 200 && phase_left > 20)
            begin
                stall     = 500;
                hold_done = 1'b1;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got.status = status_t'(m_tdata[1:0]);
            got.found  = m_tdata[7:2];
            got.rdval  = m_tdata[39:8];
            got.count  = m_tdata[46:40];
            check_result(got);
            rx_seen++;
        end
    end

    initial
    begin : stimulus
        int          ph;
        int          k;
        bit          grow;
        mode_t       m;
        logic [31:0] v;
        logic [6:0]  p;
        int          phase_items  [N_PHASES];
        logic [6:0]  phase_limits [N_PHASES];

        rst_n      = 1'b0;
        s_tdata    = '0;
        s_tvalid   = 1'b0;
        cfg_data   = '0;
        cfg_valid  = 1'b0;
        list_len   = 0;
        list_limit = LIMIT_RESET;
        tx_steady  = 1'b0;
        foreach (list_mem[i])
            list_mem[i] = '0;

        // empty list after reset: every position check fails
        plan_op(MODE_READ,   32'd0,        7'd0,   1'b1, ST_RANGE,     7'd0);
        plan_op(MODE_REMOVE, 32'd0,        7'd0,   1'b1, ST_RANGE,     7'd0);
        plan_op(MODE_UPDATE, 32'd1,        7'd0,   1'b1, ST_RANGE,     7'd0);
        plan_op(MODE_FIND,   32'd0,        7'd0,   1'b1, ST_NOT_FOUND, 7'd0);
        plan_op(MODE_NOP,    32'hFFFF_FFFF, 7'd127, 1'b1, ST_OK,       7'd0);
        plan_op(MODE_INSERT, 32'd5,        7'd1,   1'b1, ST_RANGE,     7'd0);
        plan_op(MODE_APPEND, 32'h7FFF_FFFF, 7'd0);
        plan_op(MODE_APPEND, 32'h8000_0000, 7'd0);
        plan_op(MODE_INSERT, 32'hFFFF_FFFF, 7'd0);
        plan_op(MODE_INSERT, 32'd0,        7'd3);
        plan_op(MODE_INSERT, 32'd1,        7'd127, 1'b1, ST_RANGE,     7'd4);
        plan_op(MODE_READ,   32'd0,        7'd0);
        plan_op(MODE_READ,   32'd0,        7'd4,   1'b1, ST_RANGE,     7'd4);
        plan_op(MODE_FIND,   32'h8000_0000, 7'd0);
        plan_op(MODE_UPDATE, 32'h5555_AAAA, 7'd1);
        plan_op(MODE_UPDATE, 32'd9,        7'd4,   1'b1, ST_RANGE,     7'd4);
        plan_op(MODE_REMOVE, 32'd0,        7'd0);
        plan_op(MODE_REMOVE, 32'd0,        7'd3,   1'b1, ST_RANGE,     7'd3);
        plan_op(MODE_REMOVE, 32'd0,        7'd2);
        plan_op(MODE_FIND,   32'd12345,    7'd0,   1'b1, ST_NOT_FOUND, 7'd2);
        // limit at the count: growth refused, full reported before a bad position
        plan_limit(7'd2);
        plan_op(MODE_APPEND, 32'd7,        7'd0,   1'b1, ST_FULL,      7'd2);
        plan_op(MODE_INSERT, 32'd7,        7'd100, 1'b1, ST_FULL,      7'd2);
        plan_limit(7'd0);
        plan_op(MODE_APPEND, 32'd8,        7'd0,   1'b1, ST_FULL,      7'd2);
        // limit below the count keeps the stored entries
        plan_limit(7'd1);
        plan_op(MODE_READ,   32'd0,        7'd1);
        plan_op(MODE_CLEAR,  32'd0,        7'd0,   1'b1, ST_OK,        7'd0);
        plan_limit(7'd127);
        plan_op(MODE_APPEND, 32'hDEAD_BEEF, 7'd0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_rows[n])
        begin
            if (plan_rows[n].is_cfg)
            begin
                wait_list_idle();
                write_limit(plan_rows[n].value[6:0]);
            end
            else
                send_request(plan_rows[n].mode, plan_rows[n].value, plan_rows[n].position,
                             plan_rows[n].typed, plan_rows[n].res);
        end

        phase_limits = '{7'd127, 7'd64, 7'd5, 7'd1, 7'd0, 7'd40, 7'd100, 7'd64, 7'd0};
        phase_limits[N_PHASES-1] = 7'($urandom_range(1, 127));
        phase_items  = '{130, 130, 70, 40, 25, 130, 130, 130, 115};

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            wait_list_idle();
            write_limit(phase_limits[ph]);
            grow = 1'b1;
            for (k = 0; k < phase_items[ph]; k++)
            begin
                phase_left = phase_items[ph] - k;
                if (k % 40 == 0)
                    grow = ($urandom_range(0, 3) != 0);
                if (k % 32 == 0)
                    tx_steady = ($urandom_range(0, 3) == 0);
                pick_request(grow, m, v, p);
                send_request(m, v, p, 1'b0, '0);
            end
        end
        phase_left = 0;

        wait_list_idle();
        // catch any stray result after the last expected one
        repeat (80) @(posedge clk);

        $display("covered %0d requests across %0d limit writes, longest list %0d entries",
                 sent_count, cfg_writes, peak_len);
        $display("results seen: ok %0d, full %0d, out of range %0d, not found %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
                 status_seen[ST_NOT_FOUND]);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
